/* hw/rtl/bsr_pkg.sv */
// Package for the 2-D block-sum rebinning block.
// Widths, configuration register indexes and the per-sample control struct.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package bsr_pkg;

    localparam int MAX_ROWS     = 1024;
    localparam int MAX_FACTOR   = 16;
    localparam int SAMPLE_WIDTH = 32;

    localparam int ROW_W  = $clog2(MAX_ROWS);
    localparam int RC_W   = $clog2(MAX_ROWS + 1);
    localparam int COL_W  = 16;
    localparam int F_W    = $clog2(MAX_FACTOR + 1);
    localparam int CNT_W  = $clog2(MAX_FACTOR);
    localparam int SUM_W  = 40;
    localparam int CFG_W  = 16;
    localparam int CIDX_W = 2;

    typedef enum logic [CIDX_W-1:0] {
        REG_ROW_COUNT  = 2'd0,
        REG_COL_COUNT  = 2'd1,
        REG_ROW_FACTOR = 2'd2,
        REG_COL_FACTOR = 2'd3
    } cfg_reg_t;

    typedef struct packed {
        logic             complete;
        logic             first_col;
        logic             emit;
        logic             last;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
    } bin_ctrl_t;

endpackage

`default_nettype wire

/* hw/rtl/bsr_line_store.sv */
// Generic single-port-write, single-port-read synchronous RAM.
// Registered read data, valid in the cycle after the read; holds when not reading.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module bsr_line_store #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 40
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output      logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/bsr_seq.sv */
// Configuration registers, matrix position counters and row accumulator.
// Produces the control word and running row sum for each accepted sample.
// Depends on bsr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bsr_seq
    import bsr_pkg::*;
(
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    cfg_wr_en,
    input  wire logic [CIDX_W-1:0]       cfg_index,
    input  wire logic [CFG_W-1:0]        cfg_wdata,
    input  wire logic                    accept,
    input  wire logic [SAMPLE_WIDTH-1:0] sample,
    output      bin_ctrl_t               ctrl,
    output      logic [SUM_W-1:0]        acc_sum
);

    localparam int COLX_W = COL_W + 1;

    logic [RC_W-1:0]  rc_reg;
    logic [COL_W-1:0] cc_reg;
    logic [F_W-1:0]   rf_reg, cf_reg;

    logic [SUM_W-1:0] acc_reg, acc_next;
    logic [ROW_W-1:0] row_pos_reg, row_pos_next, br_reg, br_next;
    logic [COL_W-1:0] col_pos_reg, col_pos_next, bc_reg, bc_next;
    logic [CNT_W-1:0] rib_reg, rib_next, cib_reg, cib_next;

    logic [RC_W-1:0]  rc_w;
    logic [F_W-1:0]   f_w;
    logic rib_done, cib_done, row_end, col_end, row_last, col_last;

    assign rc_w = cfg_wdata[RC_W-1:0];
    assign f_w  = cfg_wdata[F_W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rc_reg <= RC_W'(1);
            cc_reg <= COL_W'(1);
            rf_reg <= F_W'(1);
            cf_reg <= F_W'(1);
        end else if (cfg_wr_en) begin
            unique case (cfg_reg_t'(cfg_index))
                REG_ROW_COUNT: begin
                    if (rc_w == '0)                    rc_reg <= RC_W'(1);
                    else if (rc_w > RC_W'(MAX_ROWS))   rc_reg <= RC_W'(MAX_ROWS);
                    else                               rc_reg <= rc_w;
                end
                REG_COL_COUNT: begin
                    if (cfg_wdata[COL_W-1:0] == '0) cc_reg <= COL_W'(1);
                    else                            cc_reg <= cfg_wdata[COL_W-1:0];
                end
                REG_ROW_FACTOR: begin
                    if (f_w == '0)                     rf_reg <= F_W'(1);
                    else if (f_w > F_W'(MAX_FACTOR))   rf_reg <= F_W'(MAX_FACTOR);
                    else                               rf_reg <= f_w;
                end
                REG_COL_FACTOR: begin
                    if (f_w == '0)                     cf_reg <= F_W'(1);
                    else if (f_w > F_W'(MAX_FACTOR))   cf_reg <= F_W'(MAX_FACTOR);
                    else                               cf_reg <= f_w;
                end
            endcase
        end
    end

    assign acc_sum = acc_reg +
        {{(SUM_W-SAMPLE_WIDTH){sample[SAMPLE_WIDTH-1]}}, sample};

    assign rib_done = (F_W'(rib_reg) + F_W'(1)) >= rf_reg;
    assign cib_done = (F_W'(cib_reg) + F_W'(1)) >= cf_reg;
    assign row_end  = (RC_W'(row_pos_reg) + RC_W'(1)) >= rc_reg;
    assign col_end  = (COLX_W'(col_pos_reg) + COLX_W'(1)) >= COLX_W'(cc_reg);
    // last bin row / column: the next bin would not fit
    assign row_last = (RC_W'(row_pos_reg) + RC_W'(rf_reg)) >= rc_reg;
    assign col_last = (COLX_W'(col_pos_reg) + COLX_W'(cf_reg)) >= COLX_W'(cc_reg);

    always_comb begin
        ctrl.complete  = rib_done;
        ctrl.first_col = (cib_reg == '0);
        ctrl.emit      = rib_done && cib_done;
        ctrl.last      = row_last && col_last;
        ctrl.row       = br_reg;
        ctrl.col       = bc_reg;
    end

    always_comb begin
        acc_next     = acc_sum;
        rib_next     = rib_reg + CNT_W'(1);
        br_next      = br_reg;
        row_pos_next = row_pos_reg + ROW_W'(1);
        col_pos_next = col_pos_reg;
        cib_next     = cib_reg;
        bc_next      = bc_reg;
        if (rib_done) begin
            acc_next = '0;
            rib_next = '0;
            br_next  = br_reg + ROW_W'(1);
        end
        if (row_end) begin
            acc_next     = '0;
            rib_next     = '0;
            br_next      = '0;
            row_pos_next = '0;
            if (col_end) begin
                col_pos_next = '0;
                cib_next     = '0;
                bc_next      = '0;
            end else begin
                col_pos_next = col_pos_reg + COL_W'(1);
                if (cib_done) begin
                    cib_next = '0;
                    bc_next  = bc_reg + COL_W'(1);
                end else begin
                    cib_next = cib_reg + CNT_W'(1);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || cfg_wr_en) begin
            acc_reg     <= '0;
            row_pos_reg <= '0;
            col_pos_reg <= '0;
            br_reg      <= '0;
            bc_reg      <= '0;
            rib_reg     <= '0;
            cib_reg     <= '0;
        end else if (accept) begin
            acc_reg     <= acc_next;
            row_pos_reg <= row_pos_next;
            col_pos_reg <= col_pos_next;
            br_reg      <= br_next;
            bc_reg      <= bc_next;
            rib_reg     <= rib_next;
            cib_reg     <= cib_next;
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/block_sum_rebinning_2d.sv */
// Top level of the 2-D block-sum rebinning block.
// Depends on bsr_pkg, bsr_seq and bsr_line_store.
//
//  channel  dir  fields (lowest bit up)                      transfer when
//  s_       in   tdata: sample[31:0]                         s_tvalid & s_tready
//  m_       out  tdata: bin_sum, bin_row, bin_col; tlast     m_tvalid & m_tready
//  cfg_     in   index, wdata (row/col count, factors)       cfg_wr_en
//
// One sample per cycle while s_tready is high; a bin's last sample is registered
// with the line-store read in stage 1, then with the column-sum add in the output register.
// Back-to-back writes to the same bin row are forwarded around the RAM.
// Reset is synchronous; no clearing pass, each entry is written before read.
// A stalled result holds the whole pipe (s_tready low) until it is taken.
`timescale 1ns / 1ps
`default_nettype none

module block_sum_rebinning_2d
    import bsr_pkg::*;
(
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    cfg_wr_en,
    input  wire logic [CIDX_W-1:0]       cfg_index,
    input  wire logic [CFG_W-1:0]        cfg_wdata,
    input  wire logic                    s_tvalid,
    output      logic                    s_tready,
    input  wire logic [SAMPLE_WIDTH-1:0] s_tdata,   // sample
    output      logic                    m_tvalid,
    input  wire logic                    m_tready,
    output      logic [71:0]             m_tdata,   // bin_sum[39:0], bin_row[49:40],
                                                    // bin_col[65:50], zero pad
    output      logic                    m_tlast    // last_bin
);

    localparam int PAD_W = 72 - SUM_W - ROW_W - COL_W;

    logic             en, accept;
    bin_ctrl_t        ctrl;
    logic [SUM_W-1:0] acc_sum;
    logic [SUM_W-1:0] rdata;

    logic             s1_valid_reg;
    bin_ctrl_t        s1_ctrl_reg;
    logic [SUM_W-1:0] s1_acc_reg;
    logic             fwd_reg;
    logic [SUM_W-1:0] fwd_data_reg;

    logic             s1_wr;
    logic [SUM_W-1:0] base, v1;

    logic             m_valid_reg;
    logic [SUM_W-1:0] m_sum_reg;
    logic [ROW_W-1:0] m_row_reg;
    logic [COL_W-1:0] m_col_reg;
    logic             m_last_reg;

    assign en       = !m_valid_reg || m_tready;
    assign s_tready = en;
    assign accept   = s_tvalid && en;

    bsr_seq u_seq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .accept    (accept),
        .sample    (s_tdata),
        .ctrl      (ctrl),
        .acc_sum   (acc_sum)
    );

    assign s1_wr = s1_valid_reg && s1_ctrl_reg.complete;
    assign base  = fwd_reg ? fwd_data_reg : rdata;
    assign v1    = s1_ctrl_reg.first_col ? s1_acc_reg : base + s1_acc_reg;

    bsr_line_store #(
        .DEPTH (MAX_ROWS),
        .WIDTH (SUM_W)
    ) u_store (
        .aclk  (aclk),
        .we    (en && s1_wr),
        .waddr (s1_ctrl_reg.row),
        .wdata (v1),
        .re    (accept && ctrl.complete),
        .raddr (ctrl.row),
        .rdata (rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            fwd_reg      <= 1'b0;
        end else if (en) begin
            s1_valid_reg <= accept;
            fwd_reg      <= s1_wr && (s1_ctrl_reg.row == ctrl.row);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s1_ctrl_reg  <= ctrl;
            s1_acc_reg   <= acc_sum;
            fwd_data_reg <= v1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= s1_wr && s1_ctrl_reg.emit;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_sum_reg  <= v1;
            m_row_reg  <= s1_ctrl_reg.row;
            m_col_reg  <= s1_ctrl_reg.col;
            m_last_reg <= s1_ctrl_reg.last;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{PAD_W{1'b0}}, m_col_reg, m_row_reg, m_sum_reg};
    assign m_tlast  = m_last_reg;

endmodule

`default_nettype wire

/* tb/block_sum_rebinning_2d_tb.sv */
// Self-checking testbench for block_sum_rebinning_2d: 2-D block-sum binning of a
// column-major sample stream, checked against an in-bench bin predictor.
// Depends on bsr_pkg and the block_sum_rebinning_2d RTL.
`timescale 1ns / 1ps

module block_sum_rebinning_2d_tb;
    import bsr_pkg::*;

    localparam int DRAIN_CYCLES = 8;
    localparam int ROW_LO       = SUM_W;
    localparam int COL_LO       = SUM_W + ROW_W;

    typedef struct {
        logic [SUM_W-1:0] sum;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic             last;
    } bin_result_t;

    logic                    aclk      = 1'b0;
    logic                    aresetn   = 1'b0;
    logic                    cfg_wr_en = 1'b0;
    logic [CIDX_W-1:0]       cfg_index = '0;
    logic [CFG_W-1:0]        cfg_wdata = '0;
    logic                    s_tvalid  = 1'b0;
    logic                    s_tready;
    logic [SAMPLE_WIDTH-1:0] s_tdata   = '0;
    logic                    m_tvalid;
    logic                    m_tready  = 1'b0;
    logic [71:0]             m_tdata;
    logic                    m_tlast;

    // bin predictor state
    int unsigned      n_rows = 1, n_cols = 1, f_row = 1, f_col = 1;
    int unsigned      row_pos = 0, col_pos = 0, row_in = 0, col_in = 0;
    logic [SUM_W-1:0] row_acc = '0;
    logic [SUM_W-1:0] col_group_sums [MAX_ROWS];
    bin_result_t      expected_bins [$];

    int unsigned snd_idle_pct  = 0;
    int unsigned rcv_stall_pct = 0;
    int          hold_left     = 0;
    int          errors        = 0;

    block_sum_rebinning_2d DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    always begin
        aclk = 1'b1;
        #2;
        aclk = 1'b0;
        #2;
    end

    task automatic note_mismatch(input string msg);
        if (errors < 50) begin
            $display("mismatch at %0t: %s", $time, msg);
        end
        errors++;
    endtask

    function automatic int unsigned clamp_field(input int unsigned v, input int unsigned hi);
        if (v == 0) return 1;
        if (v > hi) return hi;
        return v;
    endfunction

    task automatic restart_matrix();
        row_acc = '0;
        row_pos = 0;
        col_pos = 0;
        row_in  = 0;
        col_in  = 0;
    endtask

    // advance the predictor by one accepted sample
    task automatic bin_sample(input logic [SAMPLE_WIDTH-1:0] v);
        int unsigned      row_bins, col_bins, br, bc;
        logic [SUM_W-1:0] s;
        bin_result_t      r;
        row_bins = n_rows / f_row;
        col_bins = n_cols / f_col;
        br       = row_pos / f_row;
        bc       = col_pos / f_col;
        row_acc  = row_acc + {{(SUM_W-SAMPLE_WIDTH){v[SAMPLE_WIDTH-1]}}, v};
        if (row_in + 1 >= f_row) begin
            if (br < row_bins && bc < col_bins) begin
                s = (col_in == 0) ? row_acc : col_group_sums[br] + row_acc;
                col_group_sums[br] = s;
                if (col_in + 1 >= f_col) begin
                    r.sum  = s;
                    r.row  = br[ROW_W-1:0];
                    r.col  = bc[COL_W-1:0];
                    r.last = (br + 1 == row_bins) && (bc + 1 == col_bins);
                    expected_bins.push_back(r);
                end
            end
            row_acc = '0;
            row_in  = 0;
        end else begin
            row_in++;
        end
        if (row_pos + 1 >= n_rows) begin
            row_pos = 0;
            row_in  = 0;
            row_acc = '0;
            if (col_pos + 1 >= n_cols) begin
                col_pos = 0;
                col_in  = 0;
            end else begin
                col_pos++;
                col_in = (col_in + 1 >= f_col) ? 0 : col_in + 1;
            end
        end else begin
            row_pos++;
        end
    endtask

    task automatic send_sample(input logic [SAMPLE_WIDTH-1:0] v);
        while ($urandom_range(0, 99) < snd_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= v;
        do @(posedge aclk); while (!s_tready);
        bin_sample(v);
    endtask

    task automatic wait_results();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (expected_bins.size() != 0);
    endtask

    task automatic wait_drained();
        wait_results();
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [CFG_W-1:0] val);
        wait_drained();
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            REG_ROW_COUNT:  n_rows = clamp_field(32'(val[RC_W-1:0]), MAX_ROWS);
            REG_COL_COUNT:  n_cols = clamp_field(32'(val), 32'hFFFF);
            REG_ROW_FACTOR: f_row  = clamp_field(32'(val[F_W-1:0]), MAX_FACTOR);
            REG_COL_FACTOR: f_col  = clamp_field(32'(val[F_W-1:0]), MAX_FACTOR);
            default: ;
        endcase
        restart_matrix();
    endtask

    task automatic set_config(input logic [CFG_W-1:0] rows, input logic [CFG_W-1:0] cols,
                              input logic [CFG_W-1:0] rf, input logic [CFG_W-1:0] cf);
        write_reg(REG_ROW_COUNT, rows);
        write_reg(REG_COL_COUNT, cols);
        write_reg(REG_ROW_FACTOR, rf);
        write_reg(REG_COL_FACTOR, cf);
    endtask

    function automatic logic [SAMPLE_WIDTH-1:0] random_sample();
        case ($urandom_range(0, 9))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            default: return $urandom;
        endcase
    endfunction

    // receiver: random stalls, plus long hold-offs on request
    always @(posedge aclk) begin
        if (hold_left > 0) begin
            m_tready <= 1'b0;
            hold_left--;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= rcv_stall_pct);
        end
    end

    always @(posedge aclk) begin
        bin_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_bins.size() == 0) begin
                note_mismatch("result transfer with no bin expected");
            end else begin
                want = expected_bins.pop_front();
                if (m_tdata[SUM_W-1:0] !== want.sum)
                    note_mismatch($sformatf("bin_sum %h, expected %h",
                                            m_tdata[SUM_W-1:0], want.sum));
                if (m_tdata[ROW_LO +: ROW_W] !== want.row)
                    note_mismatch($sformatf("bin_row %0d, expected %0d",
                                            m_tdata[ROW_LO +: ROW_W], want.row));
                if (m_tdata[COL_LO +: COL_W] !== want.col)
                    note_mismatch($sformatf("bin_col %0d, expected %0d",
                                            m_tdata[COL_LO +: COL_W], want.col));
                if (m_tlast !== want.last)
                    note_mismatch($sformatf("last_bin %b, expected %b", m_tlast, want.last));
            end
        end
    end

    // reset values: every sample is a bin of its own and the last one
    task automatic test_reset_defaults();
        send_sample(32'h7FFF_FFFF);
        send_sample(32'h8000_0000);
    endtask

    // one 2x2 bin of most-negative samples; row count written with junk upper bits
    task automatic test_full_block();
        set_config(16'hF802, 16'd2, 16'd2, 16'd2);
        repeat (4) send_sample(32'h8000_0000);
    endtask

    // a write mid-matrix restarts the positions and the running sums
    task automatic test_restart_on_write();
        repeat (3) send_sample(32'h1234_5678);
        write_reg(REG_COL_FACTOR, 16'd2);
        repeat (4) send_sample(32'h7FFF_FFFF);
    endtask

    // trailing row and column do not fill a bin and are dropped
    task automatic test_partial_bins_dropped();
        set_config(16'd3, 16'd3, 16'd2, 16'd2);
        for (int i = 0; i < 9; i++) begin
            send_sample(i + 1);
        end
    endtask

    // factor above the count: no bin exists; zero and oversized factors clamp
    task automatic test_oversized_factor();
        set_config(16'd2, 16'd1, 16'h001F, 16'd0);
        send_sample($urandom);
        send_sample($urandom);
    endtask

    // receiver holds off long enough to back up the pipe, then sender drains
    task automatic test_backpressure();
        set_config(16'd4, 16'd4, 16'd1, 16'd1);
        snd_idle_pct  = 0;
        rcv_stall_pct = 0;
        hold_left     = 200;
        repeat (24) send_sample(random_sample());
        wait_results();
        repeat (16) send_sample(random_sample());
    endtask

    task automatic pick_config();
        int unsigned r, c;
        r = $urandom_range(1, 10);
        c = $urandom_range(1, 10);
        case ($urandom_range(0, 7))
            0: set_config(16'd1, CFG_W'($urandom_range(1, 65535)),
                          16'd1, CFG_W'($urandom_range(1, 16)));
            1: set_config($urandom_range(0, 1) ? CFG_W'(MAX_ROWS) : 16'h07FF,
                          CFG_W'($urandom_range(1, 8)),
                          $urandom_range(0, 1) ? CFG_W'(MAX_FACTOR) : 16'h001F,
                          CFG_W'($urandom_range(1, 2)));
            2: set_config(CFG_W'($urandom_range(0, 65535)), CFG_W'($urandom_range(0, 65535)),
                          CFG_W'($urandom_range(0, 65535)), CFG_W'($urandom_range(0, 65535)));
            3: set_config(16'd0, 16'hFFFF, 16'd0, CFG_W'(MAX_FACTOR));
            default: set_config(CFG_W'(r), CFG_W'(c),
                                CFG_W'($urandom_range(1, r + 1)),
                                CFG_W'($urandom_range(1, c + 1)));
        endcase
    endtask

    task automatic test_random_streams();
        int unsigned snd_pct [4] = '{0, 72, 0, 12};
        int unsigned rcv_pct [4] = '{0, 0, 72, 12};
        for (int p = 0; p < 4; p++) begin
            snd_idle_pct  = snd_pct[p];
            rcv_stall_pct = rcv_pct[p];
            repeat (6) begin
                pick_config();
                repeat (80) begin
                    if ($urandom_range(0, 199) == 0) begin
                        wait_results();
                    end
                    send_sample(random_sample());
                end
            end
        end
    endtask

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_reset_defaults();
        test_full_block();
        test_restart_on_write();
        test_partial_bins_dropped();
        test_oversized_factor();
        test_backpressure();
        test_random_streams();
        wait_drained();
        if (errors == 0) begin
            $display("[block_sum_rebinning_2d] OK");
        end else begin
            $display("[block_sum_rebinning_2d] ERROR");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("[block_sum_rebinning_2d] ERROR");
        $finish;
    end

endmodule
